### rtl/core/gre_pkg.sv
// shared types and constants for the glyph row expander
// no dependencies; imported by gre_byte_lane, glyph_row_expander_4bpp and the testbench files
package gre_pkg;

	localparam int NIB_W       = 4;
	localparam int ROW_W       = 8;
	localparam int ROW_IDX_W   = 3;
	localparam int LANES       = 4;
	localparam int PIX_W       = 16;
	localparam int ADDR_W      = 15;
	localparam int WORD_W      = 32;
	localparam int GLYPH_W     = 64;
	localparam int CROW_W      = 5;
	localparam int CCOL_W      = 6;
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 48;

	localparam logic [ROW_IDX_W-1:0] LAST_ROW = 3'd7;

	typedef logic [NIB_W-1:0] nib_t;
	typedef logic [ROW_W-1:0] byte_t;

endpackage

### rtl/core/glyph_row_expander_4bpp.sv
// Glyph row expander: one 8x8 one-bit glyph in, eight 4bpp framebuffer row writes out.
// Each input beat yields eight output beats, one per pixel row, tlast on the eighth.
// The output channel carries one row per beat, and the next glyph is taken in the
// same cycle its predecessor's last row moves to the output register, so glyphs
// stream with no gap. The first row passes through the hold stage and then the
// output register. The row address starts from one multiply at acceptance and then steps
// by LINE_PIXELS per row; four byte lanes build the row word in parallel.
// depends on gre_pkg and gre_byte_lane
module glyph_row_expander_4bpp #(
	parameter int LINE_PIXELS = 288
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// glyph_bits[63:0], cell_row[68:64], cell_col[74:69], fore_color[78:75],
	// back_color[82:79], row_offset[85:83], zero pad[87:86]
	input  logic [gre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// byte_address[14:0], pixel_bytes[46:15], zero pad[47]
	output logic [gre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                          m_axis_tlast   // last_row
);
	import gre_pkg::*;

	// input field split
	logic [GLYPH_W-1:0]   in_glyph;
	logic [CROW_W-1:0]    in_crow;
	logic [CCOL_W-1:0]    in_ccol;
	nib_t                 in_fg;
	nib_t                 in_bg;
	logic [ROW_IDX_W-1:0] in_off;

	assign in_glyph = s_axis_tdata[63:0];
	assign in_crow  = s_axis_tdata[68:64];
	assign in_ccol  = s_axis_tdata[74:69];
	assign in_fg    = s_axis_tdata[78:75];
	assign in_bg    = s_axis_tdata[82:79];
	assign in_off   = s_axis_tdata[85:83];

	// base pixel offset of the cell's top row, modulo 2^16 (address keeps 15 bits after halving)
	logic [PIX_W-1:0] line_step;
	logic [23:0]      base_prod;
	logic [PIX_W-1:0] base_pix;

	assign line_step = PIX_W'(LINE_PIXELS);
	assign base_prod = {16'b0, in_crow, 3'b000} * {8'b0, line_step};
	assign base_pix  = base_prod[PIX_W-1:0] + {7'b0, in_ccol, 3'b000};

	// glyph hold stage
	logic                 hold_valid_q;
	logic [GLYPH_W-1:0]   glyph_q;
	nib_t                 fg_q;
	nib_t                 bg_q;
	logic [ROW_IDX_W-1:0] src_q;
	logic [ROW_IDX_W-1:0] row_q;
	logic [PIX_W-1:0]     pix_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_last_q;

	logic adv;
	logic take;

	assign adv           = hold_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !hold_valid_q || (adv && row_q == LAST_ROW);
	assign take          = s_axis_tvalid && s_axis_tready;

	// lanes
	byte_t            src_row;
	byte_t            lane_bytes [LANES];
	logic [WORD_W-1:0] row_word;

	assign src_row = glyph_q[ROW_W*src_q +: ROW_W];

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		gre_byte_lane u_lane (
			.pair_bits (src_row[ROW_W-1-2*k -: 2]),
			.fore_color(fg_q),
			.back_color(bg_q),
			.lane_byte (lane_bytes[k])
		);
	end

	// merge: byte k lands at bits 31-8k..24-8k
	always_comb begin
		row_word = '0;
		for (int k = 0; k < LANES; k++) begin
			row_word[WORD_W-1-ROW_W*k -: ROW_W] = lane_bytes[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			row_q        <= '0;
		end else begin
			if (take) begin
				hold_valid_q <= 1'b1;
				row_q        <= '0;
			end else if (adv) begin
				if (row_q == LAST_ROW) begin
					hold_valid_q <= 1'b0;
				end
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			glyph_q <= in_glyph;
			fg_q    <= in_fg;
			bg_q    <= in_bg;
			src_q   <= in_off;
			pix_q   <= base_pix;
		end else if (adv) begin
			src_q <= src_q + 1'b1;
			pix_q <= pix_q + line_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {1'b0, row_word, pix_q[PIX_W-1:1]};
			out_last_q <= (row_q == LAST_ROW);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// a new glyph only enters over an occupied hold stage when its last row leaves
	a_take_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && hold_valid_q) |-> (adv && row_q == LAST_ROW))
		else $error("glyph accepted while rows still pending");

	// tlast tracks the row that was moved out
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (m_axis_tlast == ($past(row_q) == LAST_ROW)))
		else $error("tlast does not match row index");

	// within a glyph the pixel offset steps by one line per row
	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !take) |=> (pix_q == $past(pix_q) + line_step))
		else $error("row address step wrong");

	// row counter and source row stay locked by the rotation
	a_src_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !take) |=> (src_q - row_q == $past(src_q) - $past(row_q)))
		else $error("source row drifted from output row");

endmodule

### rtl/core/gre_byte_lane.sv
// one lane: expands two glyph bits into one packed byte, even pixel in the high nibble
// depends on gre_pkg
module gre_byte_lane (
	input  logic [1:0]    pair_bits,  // [1] even pixel, [0] odd pixel
	input  gre_pkg::nib_t fore_color,
	input  gre_pkg::nib_t back_color,
	output gre_pkg::byte_t lane_byte
);
	import gre_pkg::*;

	nib_t even_nib;
	nib_t odd_nib;

	assign even_nib  = pair_bits[1] ? fore_color : back_color;
	assign odd_nib   = pair_bits[0] ? fore_color : back_color;
	assign lane_byte = {even_nib, odd_nib};

endmodule

### tb/glyph_row_checker.sv
`timescale 1ns / 1ps
// scoreboard for the glyph row expander: predicts the eight row writes of each glyph beat
// and compares every output beat in order; depends on gre_pkg
module glyph_row_checker #(
	parameter int LINE_PIXELS = 288
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [gre_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [gre_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast,
	output int                              fail_count,
	output int                              rows_pending
);
	import gre_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] pixels;
		logic              last;
	} row_write_t;

	row_write_t rows_due[$];

	initial begin
		fail_count = 0;
		rows_pending = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// msb of the glyph row is the leftmost pixel, which lands in the top nibble
	function automatic logic [WORD_W-1:0] expand_row(input byte_t row_bits, input nib_t fore,
			input nib_t back);
		logic [WORD_W-1:0] word;
		int p;
		word = '0;
		for (p = 0; p < 8; p++)
			word[WORD_W-1-NIB_W*p -: NIB_W] = row_bits[7-p] ? fore : back;
		return word;
	endfunction

	task automatic queue_glyph_rows(input logic [IN_TDATA_W-1:0] beat);
		logic [GLYPH_W-1:0]   glyph;
		logic [CROW_W-1:0]    crow;
		logic [CCOL_W-1:0]    ccol;
		nib_t                 fore;
		nib_t                 back;
		logic [ROW_IDX_W-1:0] rot;
		logic [ROW_IDX_W-1:0] src;
		logic [31:0]          pix;
		row_write_t           w;
		int                   r;
		glyph = beat[63:0];
		crow  = beat[68:64];
		ccol  = beat[74:69];
		fore  = beat[78:75];
		back  = beat[82:79];
		rot   = beat[85:83];
		for (r = 0; r < 8; r++) begin
			// 3-bit sum wraps, giving the rotation mod 8
			src = ROW_IDX_W'(r) + rot;
			// linear pixel offset, no range check; the byte address wraps at 15 bits
			pix = (32'(crow) * 8 + 32'(r)) * LINE_PIXELS + 32'(ccol) * 8;
			w.addr   = pix[ADDR_W:1];
			w.pixels = expand_row(glyph[8*src +: 8], fore, back);
			w.last   = (ROW_IDX_W'(r) == LAST_ROW);
			rows_due.push_back(w);
		end
	endtask

	task automatic check_row_write(input logic [OUT_TDATA_W-1:0] beat, input logic last);
		row_write_t want;
		if (rows_due.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, data %h last %b", beat, last));
			return;
		end
		want = rows_due.pop_front();
		if (beat[14:0] !== want.addr)
			report_mismatch($sformatf("byte_address %h, want %h", beat[14:0], want.addr));
		if (beat[46:15] !== want.pixels)
			report_mismatch($sformatf("pixel_bytes %h, want %h (address %h)",
				beat[46:15], want.pixels, want.addr));
		if (last !== want.last)
			report_mismatch($sformatf("last_row %b, want %b (address %h)",
				last, want.last, want.addr));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				queue_glyph_rows(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				check_row_write(m_axis_tdata, m_axis_tlast);
			rows_pending <= rows_due.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// top of the glyph row expander bench: clock, reset, glyph stimulus and output backpressure
// depends on gre_pkg, glyph_row_expander_4bpp and glyph_row_checker
module testbench;
	import gre_pkg::*;

	localparam int LINE_PIXELS   = 288;
	localparam int RANDOM_GLYPHS = 220;
	localparam int QUIET_GLYPHS  = 40;
	localparam int LONG_HOLD     = 150;
	localparam int DRAIN_CYCLES  = 30;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct {
		logic [GLYPH_W-1:0]   glyph;
		logic [CROW_W-1:0]    crow;
		logic [CCOL_W-1:0]    ccol;
		nib_t                 fore;
		nib_t                 back;
		logic [ROW_IDX_W-1:0] rot;
	} glyph_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	int                     fail_count;
	int                     rows_pending;
	int                     sent_count;
	bit                     no_idle;

	glyph_row_expander_4bpp #(.LINE_PIXELS(LINE_PIXELS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	glyph_row_checker #(.LINE_PIXELS(LINE_PIXELS)) row_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.fail_count   (fail_count),
		.rows_pending (rows_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	// holds one beat until taken, then sometimes leaves a short gap
	task automatic send_glyph(input glyph_beat_t g);
		s_axis_tdata  <= {2'b00, g.rot, g.back, g.fore, g.ccol, g.crow, g.glyph};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sent_count++;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic glyph_beat_t random_glyph();
		glyph_beat_t g;
		case ($urandom_range(0, 9))
			0: g.glyph = '0;
			1: g.glyph = '1;
			2: g.glyph = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: g.glyph = {$urandom, $urandom};
		endcase
		// mostly on screen, sometimes past the last cell row or the line end
		g.crow = ($urandom_range(0, 9) == 0) ? CROW_W'($urandom_range(28, 31))
			: CROW_W'($urandom_range(0, 27));
		g.ccol = ($urandom_range(0, 9) == 0) ? CCOL_W'($urandom_range(36, 63))
			: CCOL_W'($urandom_range(0, 35));
		g.fore = NIB_W'($urandom_range(0, 15));
		g.back = NIB_W'($urandom_range(0, 15));
		g.rot  = ROW_IDX_W'($urandom_range(0, 7));
		return g;
	endfunction

	initial begin : sink
		bit long_hold_done;
		long_hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_hold_done && sent_count >= 60) begin
				// long back-pressure so the block fills up and drops s_axis_tready
				long_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat (no_idle ? 1 : $urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int k;
		no_idle    = 1'b0;
		sent_count = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blank and solid glyphs, then every rotation of a glyph with distinct rows
		send_glyph('{glyph: '0, crow: 0, ccol: 0, fore: 4'hF, back: 4'h0, rot: 0});
		send_glyph('{glyph: '1, crow: 0, ccol: 0, fore: 4'h5, back: 4'hA, rot: 0});
		for (k = 0; k < 8; k++)
			send_glyph('{glyph: 64'h8040_2010_0804_0201, crow: 3, ccol: 7, fore: 4'h9,
				back: 4'h6, rot: ROW_IDX_W'(k)});
		// equal colors
		send_glyph('{glyph: 64'hAA55_AA55_AA55_AA55, crow: 1, ccol: 2, fore: 4'hF, back: 4'hF,
			rot: 1});
		send_glyph('{glyph: 64'h55AA_55AA_55AA_55AA, crow: 2, ccol: 1, fore: 4'h0, back: 4'h0,
			rot: 6});
		// last on-screen cell, then positions past the screen and the line end
		send_glyph('{glyph: 64'h0123_4567_89AB_CDEF, crow: 27, ccol: 35, fore: 4'h1,
			back: 4'hE, rot: 3});
		send_glyph('{glyph: 64'hFEDC_BA98_7654_3210, crow: 28, ccol: 0, fore: 4'hC, back: 4'h3,
			rot: 5});
		send_glyph('{glyph: 64'hF0F0_0F0F_FF00_00FF, crow: 31, ccol: 63, fore: 4'hF,
			back: 4'h0, rot: 7});
		send_glyph('{glyph: 64'h8181_4242_2424_1818, crow: 0, ccol: 36, fore: 4'h7, back: 4'h8,
			rot: 2});
		send_glyph('{glyph: 64'hDEAD_BEEF_C0DE_F00D, crow: 13, ccol: 63, fore: 4'hB,
			back: 4'h4, rot: 7});
		send_glyph('{glyph: 64'h7E81_A581_A599_817E, crow: 31, ccol: 0, fore: 4'h0, back: 4'hF,
			rot: 4});

		for (k = 0; k < RANDOM_GLYPHS; k++) begin
			if (k == RANDOM_GLYPHS - QUIET_GLYPHS)
				no_idle = 1'b1;
			send_glyph(random_glyph());
		end
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (rows_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
